// File: rtl/istk_pkg.sv
package istk_pkg;

    localparam int DATA_W   = 32;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;
    localparam int LIMIT_W  = 5;

    localparam logic [OPCODE_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ADD  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FEW  = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd15;

    typedef logic signed [DATA_W-1:0] word_t;

endpackage

// File: rtl/istk_req_if.sv
interface istk_req_if
    import istk_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    word_t               push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

// File: rtl/istk_rsp_if.sv
interface istk_rsp_if
    import istk_pkg::*;
;
    logic                valid;
    logic                ready;
    word_t               pop_value;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill_count;

    modport source (output valid, output pop_value, output status, output fill_count,
                    input ready);
    modport sink   (input valid, input pop_value, input status, input fill_count,
                    output ready);
endinterface

// File: rtl/istk_cfg_if.sv
interface istk_cfg_if
    import istk_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] capacity_limit;

    modport source (output valid, output capacity_limit, input ready);
    modport sink   (input valid, input capacity_limit, output ready);
endinterface

// File: rtl/integer_stack_with_add.sv
// LIFO stack of signed 32-bit words held in a synchronous memory of DEPTH entries.
// Each request transaction carries push, pop or add-top-two and yields exactly one
// response transaction with the popped value, a status and the fill count after the
// request. Push, an unused opcode and any error are answered from the idle state; pop
// and add pass through a read state, as the top entries leave the stack memory in the
// cycle after the read is issued; no request is taken in that state. Pushes run at one
// per cycle while responses are taken. A new request is taken while the previous
// response waits, as long as the consumer takes it in the same cycle. Push reports
// full once the fill count reaches the smaller of capacity_limit and DEPTH; the limit
// resets to 15. The user must write it only while idle; the block does not enforce it.
module integer_stack_with_add
    import istk_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    istk_req_if.sink   req,
    istk_rsp_if.source rsp,
    istk_cfg_if.sink   cfg
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = $clog2(DEPTH + 1);
    localparam int CW = (PW > LIMIT_W) ? PW : LIMIT_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [PW-1:0]       top_reg, top_next;
    logic                is_add_reg, is_add_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic                rsp_valid_reg, rsp_valid_next;
    word_t               pop_value_reg, pop_value_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;

    word_t               mem [DEPTH];
    word_t               rd_a_reg, rd_b_reg;
    logic [AW-1:0]       rd_addr_a, rd_addr_b;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    word_t               mem_wdata;

    logic                req_acc;
    logic                full;
    logic [CW-1:0]       top_ext;

    assign cfg.ready = 1'b1;

    assign req.ready      = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign req_acc        = req.valid && req.ready;
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.pop_value  = pop_value_reg;
    assign rsp.status     = status_reg;
    assign rsp.fill_count = fill_reg;

    assign top_ext   = CW'(top_reg);
    assign full      = (top_ext >= CW'(limit_reg)) || (top_ext >= CW'(DEPTH));
    assign rd_addr_a = AW'(top_reg - PW'(1));
    assign rd_addr_b = AW'(top_reg - PW'(2));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        is_add_next    = is_add_reg;
        rsp_valid_next = rsp_valid_reg;
        pop_value_next = pop_value_reg;
        status_next    = status_reg;
        fill_next      = fill_reg;
        mem_we         = 1'b0;
        mem_waddr      = AW'(top_reg);
        mem_wdata      = req.push_value;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    pop_value_next = '0;
                    status_next    = ST_OK;
                    fill_next      = FILL_W'(top_reg);
                    rsp_valid_next = 1'b1;
                    priority if (req.opcode == OP_PUSH)
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            top_next  = top_reg + PW'(1);
                            fill_next = FILL_W'(top_reg + PW'(1));
                        end
                    end
                    else if (req.opcode == OP_POP)
                    begin
                        if (top_reg == '0)
                        begin
                            status_next = ST_FEW;
                        end
                        else
                        begin
                            top_next       = top_reg - PW'(1);
                            is_add_next    = 1'b0;
                            rsp_valid_next = 1'b0;
                            state_next     = S_READ;
                        end
                    end
                    else if (req.opcode == OP_ADD)
                    begin
                        if (top_reg < PW'(2))
                        begin
                            status_next = ST_FEW;
                        end
                        else
                        begin
                            top_next       = top_reg - PW'(1);
                            is_add_next    = 1'b1;
                            rsp_valid_next = 1'b0;
                            state_next     = S_READ;
                        end
                    end
                    else
                    begin
                        status_next = ST_OK;
                    end
                end
            end
            S_READ:
            begin
                mem_we         = is_add_reg;
                mem_waddr      = AW'(top_reg - PW'(1));
                mem_wdata      = rd_a_reg + rd_b_reg;
                pop_value_next = is_add_reg ? word_t'(0) : rd_a_reg;
                status_next    = ST_OK;
                fill_next      = FILL_W'(top_reg);
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_reg       <= '0;
            is_add_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            is_add_reg    <= is_add_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid)
            begin
                limit_reg <= cfg.capacity_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pop_value_reg <= pop_value_next;
        status_reg    <= status_next;
        fill_reg      <= fill_next;
    end

`ifndef SYNTHESIS
    a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= PW'(DEPTH))
        else $error("stack pointer beyond depth");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !rsp_valid_reg)
        else $error("response slot busy during memory read");

    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_IDLE) && rsp_valid_reg)
        else $error("read cycle did not complete");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && (req.opcode == OP_PUSH) && !full)
            |=> (top_reg == $past(top_reg) + PW'(1)))
        else $error("push did not advance pointer");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && ((req.opcode == OP_POP) || (req.opcode == OP_ADD))
            && (top_reg >= PW'(2)))
            |=> (top_reg == $past(top_reg) - PW'(1)) && (state_reg == S_READ))
        else $error("pop or add did not retire pointer");
`endif

endmodule

// File: dv/integer_stack_with_add_tb.sv
`timescale 1ns / 1ps

module integer_stack_with_add_tb;

    import istk_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam word_t WORD_MAX = 32'sh7fff_ffff;
    localparam word_t WORD_MIN = 32'sh8000_0000;

    typedef struct {
        word_t               pop_value;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   fill_count;
    } stack_result_t;

    logic clk;
    logic rst_n;

    istk_req_if req_if ();
    istk_rsp_if rsp_if ();
    istk_cfg_if cfg_if ();

    integer_stack_with_add #(
        .DEPTH (STACK_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    stack_result_t      pending_results[$];
    word_t              shadow_stack[STACK_DEPTH];
    int                 shadow_fill;
    logic [LIMIT_W-1:0] shadow_limit;

    int error_count;
    int cycle_count;
    int req_idle_pct;
    int rsp_stall_pct;
    int rsp_hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("** integer_stack_with_add: FAILED **");
        $finish;
    end

    function automatic void predict_stack_op(input logic [OPCODE_W-1:0] op, input word_t value);
        stack_result_t res;
        int            lim;
        word_t         top_a;
        word_t         top_b;
        res.pop_value = '0;
        res.status    = ST_OK;
        lim = (int'(shadow_limit) > STACK_DEPTH) ? STACK_DEPTH : int'(shadow_limit);
        case (op)
            OP_PUSH:
            begin
                if (shadow_fill >= lim)
                    res.status = ST_FULL;
                else
                begin
                    shadow_stack[shadow_fill] = value;
                    shadow_fill++;
                end
            end
            OP_POP:
            begin
                if (shadow_fill < 1)
                    res.status = ST_FEW;
                else
                begin
                    shadow_fill--;
                    res.pop_value = shadow_stack[shadow_fill];
                end
            end
            OP_ADD:
            begin
                if (shadow_fill < 2)
                    res.status = ST_FEW;
                else
                begin
                    top_a = shadow_stack[shadow_fill-1];
                    top_b = shadow_stack[shadow_fill-2];
                    shadow_fill--;
                    shadow_stack[shadow_fill-1] = top_a + top_b;
                end
            end
            default:
            begin
            end
        endcase
        res.fill_count = shadow_fill[FILL_W-1:0];
        pending_results.push_back(res);
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
            error_count++;
        end
    endfunction

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_cycles > 0)
            begin
                rsp_hold_cycles--;
                rsp_if.ready = 1'b0;
            end
            else
                rsp_if.ready = ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    always @(posedge clk)
    begin : response_check
        stack_result_t oldest;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transaction pop_value=%h status=%0d fill_count=%0d",
                         $time, rsp_if.pop_value, rsp_if.status, rsp_if.fill_count);
                error_count++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                check_field("pop_value", oldest.pop_value, rsp_if.pop_value);
                check_field("status", 32'(oldest.status), 32'(rsp_if.status));
                check_field("fill_count", 32'(oldest.fill_count), 32'(rsp_if.fill_count));
            end
        end
    end

    task automatic send_request(input logic [OPCODE_W-1:0] op, input word_t value);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid      = 1'b1;
        req_if.opcode     = op;
        req_if.push_value = value;
        do
            @(posedge clk);
        while (!req_if.ready);
        predict_stack_op(op, value);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        req_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] limit);
        wait_for_results();
        cfg_if.valid          = 1'b1;
        cfg_if.capacity_limit = limit;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        shadow_limit = limit;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic word_t random_word();
        case ($urandom_range(9))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return -1;
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic test_empty_stack_errors();
        send_request(OP_POP, random_word());
        send_request(OP_ADD, random_word());
        send_request(OP_UNUSED, random_word());
    endtask

    task automatic test_add_wraparound();
        send_request(OP_PUSH, WORD_MAX);
        send_request(OP_ADD, '0);
        send_request(OP_PUSH, 32'sd1);
        send_request(OP_ADD, '0);
        send_request(OP_PUSH, -1);
        send_request(OP_ADD, '0);
        send_request(OP_POP, '0);
    endtask

    task automatic test_zero_limit();
        write_limit(5'd0);
        send_request(OP_PUSH, random_word());
        send_request(OP_UNUSED, random_word());
    endtask

    task automatic test_limit_above_depth();
        write_limit(5'd31);
        while (shadow_fill < STACK_DEPTH)
            send_request(OP_PUSH, random_word());
        send_request(OP_PUSH, random_word());
    endtask

    task automatic test_limit_below_fill();
        write_limit(5'd3);
        send_request(OP_PUSH, random_word());
        send_request(OP_ADD, '0);
        send_request(OP_POP, '0);
        send_request(OP_PUSH, random_word());
    endtask

    task automatic test_random_phase(input logic [LIMIT_W-1:0] limit, input int count,
                                     input int send_idle, input int recv_stall,
                                     input int push_pct);
        int                  roll;
        logic [OPCODE_W-1:0] op;
        write_limit(limit);
        req_idle_pct  = send_idle;
        rsp_stall_pct = recv_stall;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
                op = OP_UNUSED;
            else if (roll < 3 + push_pct)
                op = OP_PUSH;
            else if (roll < 3 + push_pct + (97 - push_pct) / 2)
                op = OP_POP;
            else
                op = OP_ADD;
            send_request(op, random_word());
        end
    endtask

    task automatic test_backpressure_fill();
        write_limit(5'd16);
        req_idle_pct    = 0;
        rsp_stall_pct   = 0;
        rsp_hold_cycles = 80;
        repeat (30)
            send_request(($urandom_range(99) < 60) ? OP_PUSH :
                         (($urandom_range(1) == 0) ? OP_POP : OP_ADD), random_word());
        wait_for_results();
    endtask

    initial
    begin
        error_count     = 0;
        req_idle_pct    = 0;
        rsp_stall_pct   = 0;
        rsp_hold_cycles = 0;
        shadow_fill     = 0;
        shadow_limit    = LIMIT_RESET;
        for (int i = 0; i < STACK_DEPTH; i++)
            shadow_stack[i] = '0;
        req_if.valid          = 1'b0;
        req_if.opcode         = OP_PUSH;
        req_if.push_value     = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.capacity_limit = LIMIT_RESET;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_stack_errors();
        test_add_wraparound();
        test_zero_limit();
        test_limit_above_depth();
        test_limit_below_fill();

        test_random_phase(5'd16, 120, 0, 0, 60);
        test_random_phase(5'd5, 100, 62, 0, 50);
        test_random_phase(5'($urandom_range(1, 16)), 100, 0, 62, 55);
        test_random_phase(5'd1, 60, 37, 37, 50);
        test_backpressure_fill();
        test_random_phase(5'd31, 100, 37, 37, 65);
        test_random_phase(5'd0, 30, 37, 37, 50);
        test_random_phase(5'd12, 100, 0, 0, 45);
        test_random_phase(5'($urandom_range(0, 31)), 60, 62, 62, 55);

        wait_for_results();
        repeat (10) @(negedge clk);
        if (error_count == 0)
            $display("** integer_stack_with_add: PASSED **");
        else
            $display("** integer_stack_with_add: FAILED **");
        $finish;
    end

endmodule
